// ===== sv/lobm_pkg.sv =====
package lobm_pkg;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  localparam logic [1:0] TIF_REST = 2'd0;
  localparam logic [1:0] TIF_IOC  = 2'd1;
  localparam logic [1:0] TIF_FOK  = 2'd2;

  localparam logic [1:0] STP_NONE     = 2'd0;
  localparam logic [1:0] STP_INCOMING = 2'd1;
  localparam logic [1:0] STP_RESTING  = 2'd2;
  localparam logic [1:0] STP_BOTH     = 2'd3;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_FOK_REJ   = 3'd3;
  localparam logic [2:0] ST_BOOK_FULL = 3'd4;
  localparam logic [2:0] ST_CANCELLED = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [31:0] order_ident;
    logic        side_sell;
    logic        market_order;
    logic [1:0]  time_in_force;
    logic [31:0] limit_price;
    logic [31:0] order_qty;
    logic [15:0] trader;
  } request_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] trade_number;
    logic [31:0] trade_price;
    logic [31:0] fill_qty;
    logic        aggressor_sell;
    logic [31:0] aggressive_ident;
    logic [31:0] passive_ident;
    logic [15:0] aggressive_trader;
    logic [15:0] passive_trader;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] ident;
    logic        sell;
    logic        market;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [15:0] trader;
    logic [31:0] arrival;
  } slot_t;

endpackage

// ===== sv/limit_order_book_matcher.sv =====
// A cancel scans the order table once. An add scans it once per fill or self-trade removal,
// plus one scan that finds nothing unless the order fills, hits the fill limit or is killed;
// fill-or-kill repeats all its scans once its dry pass has filled.
// Throughput: one request at a time; busy is high until the status beat is out.
// Reset (rst, synchronous) empties the book and clears both counters and the policy.
// Results are one-cycle beats on strobe; the receiver cannot stall.
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lobm_pkg::request_t req,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  output logic               strobe,
  output lobm_pkg::result_t  result
);
  import lobm_pkg::*;

  localparam int IW = $clog2(ORDER_SLOTS);
  localparam int NW = $clog2(ORDER_SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(ORDER_SLOTS - 1);
  localparam logic [NW-1:0] NMAX = NW'(ORDER_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  request_t rq;
  logic [1:0] policy;
  logic [ORDER_SLOTS-1:0] valid, valid_save;
  logic [31:0] arrival_counter, trade_counter, remaining;
  logic [NW-1:0] n;
  logic dry, killed, have, issuing, rd_vld;
  logic [IW-1:0] scan_i, rd_idx, best_idx;
  slot_t best, rd_data;
  slot_t mem [ORDER_SLOTS];

  logic mem_we;
  logic [IW-1:0] mem_wa;
  slot_t mem_wd;

  logic cand_ok, cand_better, price_ok, self_hit;
  logic [31:0] q, rem_after, best_rem_after;
  logic [NW-1:0] n_next;
  logic [IW-1:0] free_idx;
  logic free_found;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[scan_i];
  end

  always_comb begin
    price_ok = rq.market_order || rd_data.market ||
               (rq.side_sell ? (rq.limit_price <= rd_data.price)
                             : (rq.limit_price >= rd_data.price));
    if (rq.cmd == CMD_CANCEL) begin
      cand_ok     = valid[rd_idx] && (rd_data.ident == rq.order_ident);
      cand_better = !have || (rd_data.arrival < best.arrival);
    end else begin
      cand_ok     = valid[rd_idx] && (rd_data.sell != rq.side_sell) &&
                    (rd_data.remaining != 32'd0) && price_ok;
      if (!have) begin
        cand_better = 1'b1;
      end else if (rd_data.price == best.price) begin
        cand_better = rd_data.arrival < best.arrival;
      end else if (rq.side_sell) begin
        cand_better = rd_data.price > best.price;
      end else begin
        cand_better = rd_data.price < best.price;
      end
    end
  end

  always_comb begin
    self_hit = (policy != STP_NONE) && (rq.trader != 16'd0) && (best.trader == rq.trader);
    q = (remaining < best.remaining) ? remaining : best.remaining;
    rem_after = remaining - q;
    best_rem_after = best.remaining - q;
    n_next = n + NW'(1);
    free_found = 1'b0;
    free_idx = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = best_idx;
    mem_wd = best;
    mem_wd.remaining = best_rem_after;
    if (state == S_PICK && rq.cmd == CMD_ADD && have && !self_hit && !dry &&
        best_rem_after != 32'd0) begin
      mem_we = 1'b1;
    end else if (state == S_DONE && !dry && !killed && remaining != 32'd0 &&
                 rq.time_in_force != TIF_IOC && free_found) begin
      mem_we = 1'b1;
      mem_wa = free_idx;
      mem_wd.ident     = rq.order_ident;
      mem_wd.sell      = rq.side_sell;
      mem_wd.market    = rq.market_order;
      mem_wd.price     = rq.limit_price;
      mem_wd.remaining = remaining;
      mem_wd.trader    = rq.trader;
      mem_wd.arrival   = arrival_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      policy <= STP_NONE;
      valid <= '0;
      arrival_counter <= '0;
      trade_counter <= '0;
      strobe <= 1'b0;
      rd_vld <= 1'b0;
      issuing <= 1'b0;
      have <= 1'b0;
      dry <= 1'b0;
      killed <= 1'b0;
      scan_i <= '0;
      n <= '0;
    end else begin
      strobe <= 1'b0;
      rd_vld <= 1'b0;
      if (cfg_write) begin
        policy <= cfg_data;
      end
      result.item_kind         <= KIND_STATUS;
      result.trade_number      <= '0;
      result.trade_price       <= '0;
      result.fill_qty          <= '0;
      result.aggressor_sell    <= (rq.cmd == CMD_ADD) ? rq.side_sell : 1'b0;
      result.aggressive_ident  <= rq.order_ident;
      result.passive_ident     <= '0;
      result.aggressive_trader <= (rq.cmd == CMD_ADD) ? rq.trader : 16'd0;
      result.passive_trader    <= '0;
      result.status            <= ST_RESTED;
      result.last              <= 1'b1;
      case (state)
        S_IDLE: begin
          if (start) begin
            rq <= req;
            remaining <= req.order_qty;
            valid_save <= valid;
            dry <= (req.cmd == CMD_ADD) && (req.time_in_force == TIF_FOK);
            killed <= 1'b0;
            n <= '0;
            scan_i <= '0;
            issuing <= 1'b1;
            have <= 1'b0;
            if (req.cmd == CMD_ADD && req.order_qty == 32'd0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            rd_vld <= 1'b1;
            rd_idx <= scan_i;
            if (scan_i == LAST) begin
              issuing <= 1'b0;
            end else begin
              scan_i <= scan_i + IW'(1);
            end
          end
          if (rd_vld) begin
            if (cand_ok && cand_better) begin
              have <= 1'b1;
              best <= rd_data;
              best_idx <= rd_idx;
            end
            if (rd_idx == LAST) begin
              state <= S_PICK;
            end
          end
        end
        S_PICK: begin
          scan_i <= '0;
          issuing <= 1'b1;
          have <= 1'b0;
          if (rq.cmd == CMD_CANCEL) begin
            if (have) begin
              valid[best_idx] <= 1'b0;
            end
            strobe <= 1'b1;
            result.status <= have ? ST_CANCELLED : ST_NOT_FOUND;
            state <= S_IDLE;
          end else if (!have) begin
            state <= S_DONE;
          end else if (self_hit) begin
            if (policy == STP_INCOMING) begin
              killed <= 1'b1;
              state <= S_DONE;
            end else begin
              valid[best_idx] <= 1'b0;
              if (policy == STP_BOTH) begin
                killed <= 1'b1;
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end else begin
            if (!dry) begin
              strobe <= 1'b1;
              result.item_kind      <= KIND_TRADE;
              result.trade_number   <= trade_counter;
              result.trade_price    <= best.price;
              result.fill_qty       <= q;
              result.passive_ident  <= best.ident;
              result.passive_trader <= best.trader;
              result.last           <= 1'b0;
              trade_counter <= trade_counter + 32'd1;
            end
            remaining <= rem_after;
            n <= n_next;
            if (best_rem_after == 32'd0) begin
              valid[best_idx] <= 1'b0;
            end
            state <= (rem_after != 32'd0 && n_next < NMAX) ? S_SCAN : S_DONE;
          end
        end
        S_DONE: begin
          scan_i <= '0;
          issuing <= 1'b1;
          have <= 1'b0;
          if (dry) begin
            valid <= valid_save;
            if (killed || remaining != 32'd0) begin
              strobe <= 1'b1;
              result.status <= ST_FOK_REJ;
              state <= S_IDLE;
            end else begin
              dry <= 1'b0;
              remaining <= rq.order_qty;
              n <= '0;
              state <= (rq.order_qty != 32'd0) ? S_SCAN : S_DONE;
            end
          end else begin
            strobe <= 1'b1;
            state <= S_IDLE;
            if (killed) begin
              result.status <= ST_DROPPED;
            end else if (remaining == 32'd0) begin
              result.status <= ST_FILLED;
            end else if (rq.time_in_force == TIF_IOC) begin
              result.status <= ST_DROPPED;
            end else if (!free_found) begin
              result.status <= ST_BOOK_FULL;
            end else begin
              valid[free_idx] <= 1'b1;
              arrival_counter <= arrival_counter + 32'd1;
              result.status <= ST_RESTED;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
